// ===== hdl/rv32x_pkg.sv =====
// Package for the rv32i subset execute unit: operation codes, sizes and payload types.
// No dependencies.
`default_nettype none
package rv32x_pkg;
  localparam int DataBytes = 1024;
  localparam int MemAw = $clog2(DataBytes);
  localparam logic [31:0] MemBase = 32'h0000_0400;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_ADDI = 6'd1, OP_SUB = 6'd2, OP_LUI = 6'd3, OP_XOR = 6'd4,
    OP_XORI = 6'd5, OP_OR = 6'd6, OP_ORI = 6'd7, OP_AND = 6'd8, OP_ANDI = 6'd9,
    OP_SLL = 6'd10, OP_SRL = 6'd11, OP_SRA = 6'd12, OP_LB = 6'd13, OP_LH = 6'd14,
    OP_LW = 6'd15, OP_LBU = 6'd16, OP_LHU = 6'd17, OP_SB = 6'd18, OP_SH = 6'd19,
    OP_SW = 6'd20, OP_SLT = 6'd21, OP_SLTI = 6'd22, OP_SLTU = 6'd23,
    OP_SLTIU = 6'd24, OP_BEQ = 6'd25, OP_BNE = 6'd26, OP_BLT = 6'd27,
    OP_BGE = 6'd28, OP_BLTU = 6'd29, OP_BGEU = 6'd30, OP_JAL = 6'd31,
    OP_JALR = 6'd32
  } op_t;

  typedef struct packed {
    logic [31:0] current_pc;
    logic [31:0] immediate;
    logic [4:0]  src2_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  dest_reg;
    logic [5:0]  action;
  } in_word_t;

  typedef struct packed {
    logic        access_fault;
    logic [31:0] write_value;
    logic        wrote_reg;
    logic [31:0] next_pc;
  } out_word_t;
endpackage
`default_nettype wire

// ===== hdl/rv32i_subset_execute_unit.sv =====
// Top level of the rv32i subset execute unit: register file, byte data memory, execute stage.
// Depends on rv32x_pkg.
`default_nettype none
// channel | dir | width | fields
// in_     | in  | 88    | action, dest_reg, src1_reg, src2_reg, immediate, current_pc
// out_    | out | 72    | next_pc, wrote_reg, write_value, access_fault
// One word a cycle unless stalled. Stage 1 accepts the word and reads register file and data
// memory (four byte banks); stage 2 executes, writes back and loads the output register.
// The register file is held in flip-flops behind a read port; writes forward to stage 1.
// After reset a clearing pass over all DataBytes/4 = 256 rows runs with in_tready low.
// Stalls: out_tready low freezes both stages; words wait in stage 2 and the output register.
module rv32i_subset_execute_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,  // action, dest_reg, src1_reg, src2_reg, immediate, pc
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata  // next_pc, wrote_reg, write_value, access_fault, pad
);
  import rv32x_pkg::*;
  localparam int RowAw = MemAw - 2;
  localparam int Rows = DataBytes / 4;

  logic [31:0] rf_r [32];
  logic [7:0]  mem0 [Rows];
  logic [7:0]  mem1 [Rows];
  logic [7:0]  mem2 [Rows];
  logic [7:0]  mem3 [Rows];

  logic            clr_busy_r;
  logic [RowAw:0]  clr_cnt_r;
  logic            s2_v_r;
  in_word_t        s2_r;
  logic [31:0]     a_r, b_r;
  logic [7:0]      rd0_r, rd1_r, rd2_r, rd3_r;
  logic            ov_r;
  out_word_t       o_r;

  in_word_t iw;
  logic adv;
  assign iw = in_word_t'(in_tdata[84:0]);
  assign adv = !ov_r || out_tready;
  assign in_tready = adv && !clr_busy_r;
  logic acc;
  assign acc = in_tvalid && in_tready;

  // stage 2 decode
  logic [31:0] a, b, imm, pc, addr, off, val, nxt, ldv, sdat;
  logic [1:0]  sz;          // 0 byte, 1 half, 2 word
  logic        wr, fault, ld, st;
  logic [7:0]  wbyte [4];
  logic [3:0]  wen;
  logic [RowAw-1:0] wrow [4];
  logic [RowAw-1:0] rrow [4];
  assign a = a_r; assign b = b_r;
  assign imm = s2_r.immediate; assign pc = s2_r.current_pc;
  assign addr = a + imm;
  assign off = addr - MemBase;

  logic do_wb;
  logic [4:0] wb_idx;
  assign wb_idx = s2_r.dest_reg;

  // read-address rotation for stage 1: each bank reads its row
  logic [31:0] raddr, roff;
  logic [31:0] fa;
  always_comb begin
    fa = (iw.src1_reg == 5'd0) ? 32'd0 : rf_r[iw.src1_reg];
    if (do_wb && wb_idx == iw.src1_reg) fa = val;
    raddr = fa + iw.immediate;
    roff = raddr - MemBase;
    for (int k = 0; k < 4; k++) begin
      rrow[k] = RowAw'((roff[MemAw-1:0] + MemAw'(3 - k)) >> 2);
    end
  end

  logic [7:0] byt [4];
  always_comb begin
    byt[0] = rd0_r; byt[1] = rd1_r; byt[2] = rd2_r; byt[3] = rd3_r;
    nxt = pc + 32'd4; val = 32'd0; wr = 1'b0; fault = 1'b0; ld = 1'b0; st = 1'b0;
    sz = 2'd0; ldv = 32'd0;
    case (s2_r.action)
      OP_LH, OP_LHU, OP_SH: sz = 2'd1;
      OP_LW, OP_SW: sz = 2'd2;
      default: sz = 2'd0;
    endcase
    case (s2_r.action)
      OP_ADD: begin val = a + b; wr = 1'b1; end
      OP_ADDI: begin val = a + imm; wr = 1'b1; end
      OP_SUB: begin val = a - b; wr = 1'b1; end
      OP_LUI: begin val = imm; wr = 1'b1; end
      OP_XOR: begin val = a ^ b; wr = 1'b1; end
      OP_XORI: begin val = a ^ imm; wr = 1'b1; end
      OP_OR: begin val = a | b; wr = 1'b1; end
      OP_ORI: begin val = a | imm; wr = 1'b1; end
      OP_AND: begin val = a & b; wr = 1'b1; end
      OP_ANDI: begin val = a & imm; wr = 1'b1; end
      OP_SLL: begin val = a << b[4:0]; wr = 1'b1; end
      OP_SRL: begin val = a >> b[4:0]; wr = 1'b1; end
      OP_SRA: begin val = 32'($signed(a) >>> b[4:0]); wr = 1'b1; end
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: ld = 1'b1;
      OP_SB, OP_SH, OP_SW: st = 1'b1;
      OP_SLT: begin val = {31'd0, $signed(a) < $signed(b)}; wr = 1'b1; end
      OP_SLTI: begin val = {31'd0, $signed(a) < $signed(imm)}; wr = 1'b1; end
      OP_SLTU: begin val = {31'd0, a < b}; wr = 1'b1; end
      OP_SLTIU: begin val = {31'd0, a < imm}; wr = 1'b1; end
      OP_BEQ: if (a == b) nxt = pc + imm;
      OP_BNE: if (a != b) nxt = pc + imm;
      OP_BLT: if ($signed(a) < $signed(b)) nxt = pc + imm;
      OP_BGE: if (!($signed(a) < $signed(b))) nxt = pc + imm;
      OP_BLTU: if (a < b) nxt = pc + imm;
      OP_BGEU: if (a >= b) nxt = pc + imm;
      OP_JAL: begin val = pc + 32'd4; wr = 1'b1; nxt = pc + imm; end
      OP_JALR: begin val = pc + 32'd4; wr = 1'b1; nxt = (a + imm) & 32'hFFFF_FFFE; end
      default: ;
    endcase
    if (ld || st) begin
      case (sz)
        2'd0: fault = off > 32'(DataBytes - 1);
        2'd1: fault = off > 32'(DataBytes - 2);
        default: fault = off > 32'(DataBytes - 4);
      endcase
    end
    // gather bytes rotated by the low offset bits
    for (int k = 0; k < 4; k++) begin
      ldv[8*k +: 8] = byt[2'(off[1:0] + 2'(k))];
    end
    if (ld && !fault) begin
      wr = 1'b1;
      case (s2_r.action)
        OP_LB: val = {{24{ldv[7]}}, ldv[7:0]};
        OP_LBU: val = {24'd0, ldv[7:0]};
        OP_LH: val = {{16{ldv[15]}}, ldv[15:0]};
        OP_LHU: val = {16'd0, ldv[15:0]};
        default: val = ldv;
      endcase
    end
    if (s2_r.dest_reg == 5'd0) wr = 1'b0;
    if (!wr) val = 32'd0;
  end
  assign do_wb = s2_v_r && wr;

  // store byte lanes
  always_comb begin
    sdat = b;
    for (int k = 0; k < 4; k++) begin
      logic [1:0] lane;
      lane = 2'(2'(k) - off[1:0]);
      wbyte[k] = sdat[8*lane +: 8];
      wrow[k] = RowAw'((off[MemAw-1:0] + MemAw'(3 - k)) >> 2);
      wen[k] = s2_v_r && adv && st && !fault && (lane <= {1'b0, sz[1]} + {1'b0, sz[0]} +
               {1'b0, sz[1]} + {1'b0, sz[1]});
    end
  end

  // byte banks: clear pass, store writes, registered reads
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem0[clr_cnt_r[RowAw-1:0]] <= 8'd0; mem1[clr_cnt_r[RowAw-1:0]] <= 8'd0;
      mem2[clr_cnt_r[RowAw-1:0]] <= 8'd0; mem3[clr_cnt_r[RowAw-1:0]] <= 8'd0;
    end else begin
      if (wen[0]) mem0[wrow[0]] <= wbyte[0];
      if (wen[1]) mem1[wrow[1]] <= wbyte[1];
      if (wen[2]) mem2[wrow[2]] <= wbyte[2];
      if (wen[3]) mem3[wrow[3]] <= wbyte[3];
    end
    // read, forwarding a store of the same cycle byte by byte
    if (acc) begin
      rd0_r <= (wen[0] && wrow[0] == rrow[0]) ? wbyte[0] : mem0[rrow[0]];
      rd1_r <= (wen[1] && wrow[1] == rrow[1]) ? wbyte[1] : mem1[rrow[1]];
      rd2_r <= (wen[2] && wrow[2] == rrow[2]) ? wbyte[2] : mem2[rrow[2]];
      rd3_r <= (wen[3] && wrow[3] == rrow[3]) ? wbyte[3] : mem3[rrow[3]];
    end
  end

  // register file with write forwarding into the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) rf_r[i] <= 32'd0;
    end else if (do_wb && adv) begin
      rf_r[wb_idx] <= val;
    end
  end
  logic [31:0] fb;
  always_comb begin
    fb = (iw.src2_reg == 5'd0) ? 32'd0 : rf_r[iw.src2_reg];
    if (do_wb && wb_idx == iw.src2_reg && wb_idx != 5'd0) fb = val;
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1; clr_cnt_r <= '0; s2_v_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (RowAw+1)'(Rows - 1)) clr_busy_r <= 1'b0;
      end
      if (adv) begin
        s2_v_r <= acc;
        ov_r <= s2_v_r;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (acc) begin
      s2_r <= iw; a_r <= fa; b_r <= fb;
    end
    if (adv && s2_v_r) begin
      o_r.next_pc <= nxt; o_r.wrote_reg <= wr; o_r.write_value <= val;
      o_r.access_fault <= fault;
    end
  end
  assign out_tvalid = ov_r;
  assign out_tdata = {6'd0, o_r};

  ap_x0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[64:33] == 32'd0) else $error("value without write");
  ap_fw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65] |-> !out_tdata[32]) else $error("fault with write");
  ap_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready) else $error("accept during clear");
endmodule
`default_nettype wire

// ===== dv/rv32i_subset_execute_unit_tb.sv =====
// Self-checking bench for the rv32i subset execute unit: directed and random instruction
// streams with random stalls, predicted against a shadow register file and data memory.
// Depends on rv32x_pkg and rv32i_subset_execute_unit.
`timescale 1ns / 100ps
module rv32i_subset_execute_unit_tb;
  import rv32x_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;   // action, dest_reg, src1_reg, src2_reg, immediate, current_pc
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // next_pc, wrote_reg, write_value, access_fault, pad

  rv32i_subset_execute_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // shadow state of the core
  logic [31:0] shadow_regs [32];
  logic [7:0]  shadow_mem [DataBytes];

  in_word_t    instr_queue [$];
  out_word_t   retire_queue [$];
  int unsigned mismatches = 0;
  bit          hold_sender;
  bit          in_taken;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Gap lengths: mostly short, occasionally long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic bit signed_lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Compute retired result and update the shadow state for one instruction
  function automatic out_word_t execute_instr(in_word_t w);
    out_word_t   res;
    logic [31:0] a, b, imm, pc, nxt, val, addr, off;
    int unsigned size;
    bit          wr, fault;
    a = shadow_regs[w.src1_reg];
    b = shadow_regs[w.src2_reg];
    imm = w.immediate;
    pc = w.current_pc;
    nxt = pc + 32'd4;
    val = '0;
    wr = 1'b0;
    fault = 1'b0;
    addr = a + imm;
    off = addr - MemBase;
    size = 0;
    case (w.action)
      OP_ADD:   begin val = a + b; wr = 1; end
      OP_ADDI:  begin val = a + imm; wr = 1; end
      OP_SUB:   begin val = a - b; wr = 1; end
      OP_LUI:   begin val = imm; wr = 1; end
      OP_XOR:   begin val = a ^ b; wr = 1; end
      OP_XORI:  begin val = a ^ imm; wr = 1; end
      OP_OR:    begin val = a | b; wr = 1; end
      OP_ORI:   begin val = a | imm; wr = 1; end
      OP_AND:   begin val = a & b; wr = 1; end
      OP_ANDI:  begin val = a & imm; wr = 1; end
      OP_SLL:   begin val = a << b[4:0]; wr = 1; end
      OP_SRL:   begin val = a >> b[4:0]; wr = 1; end
      OP_SRA:   begin val = $signed(a) >>> b[4:0]; wr = 1; end
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
        size = (w.action == OP_LW) ? 4 : ((w.action == OP_LH || w.action == OP_LHU) ? 2 : 1);
        if (off > DataBytes - size) begin
          fault = 1;
        end else begin
          for (int i = 0; i < size; i++) val[8*i +: 8] = shadow_mem[off + i];
          if (w.action == OP_LB) val = {{24{val[7]}}, val[7:0]};
          if (w.action == OP_LH) val = {{16{val[15]}}, val[15:0]};
          wr = 1;
        end
      end
      OP_SB, OP_SH, OP_SW: begin
        size = (w.action == OP_SW) ? 4 : ((w.action == OP_SH) ? 2 : 1);
        if (off > DataBytes - size) fault = 1;
        else for (int i = 0; i < size; i++) shadow_mem[off + i] = b[8*i +: 8];
      end
      OP_SLT:   begin val = {31'd0, signed_lt(a, b)}; wr = 1; end
      OP_SLTI:  begin val = {31'd0, signed_lt(a, imm)}; wr = 1; end
      OP_SLTU:  begin val = {31'd0, a < b}; wr = 1; end
      OP_SLTIU: begin val = {31'd0, a < imm}; wr = 1; end
      OP_BEQ:   if (a == b) nxt = pc + imm;
      OP_BNE:   if (a != b) nxt = pc + imm;
      OP_BLT:   if (signed_lt(a, b)) nxt = pc + imm;
      OP_BGE:   if (!signed_lt(a, b)) nxt = pc + imm;
      OP_BLTU:  if (a < b) nxt = pc + imm;
      OP_BGEU:  if (a >= b) nxt = pc + imm;
      OP_JAL:   begin val = pc + 32'd4; wr = 1; nxt = pc + imm; end
      OP_JALR:  begin val = pc + 32'd4; wr = 1; nxt = (a + imm) & 32'hFFFF_FFFE; end
      default:  ;
    endcase
    if (w.dest_reg == 5'd0) wr = 0;
    if (wr) shadow_regs[w.dest_reg] = val;
    else val = '0;
    res.next_pc = nxt;
    res.wrote_reg = wr;
    res.write_value = val;
    res.access_fault = fault;
    return res;
  endfunction

  function automatic in_word_t make_instr(logic [5:0] op, logic [4:0] rd, logic [4:0] rs1,
                                          logic [4:0] rs2, logic [31:0] imm, logic [31:0] pc);
    in_word_t w;
    w.action = op;
    w.dest_reg = rd;
    w.src1_reg = rs1;
    w.src2_reg = rs2;
    w.immediate = imm;
    w.current_pc = pc;
    return w;
  endfunction

  // Immediates biased towards the data window and the extremes
  function automatic logic [31:0] pick_imm();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(MemBase - 8, MemBase + DataBytes + 8);
      1:       return $urandom_range(0, 4095) - 2048;
      2:       return {$urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000};
      3:       return $urandom_range(0, 64);
      default: return $urandom();
    endcase
  endfunction

  // Random instruction: mostly defined operations, a little noise with undefined codes
  function automatic in_word_t random_instr();
    logic [5:0] op;
    logic [4:0] rs1;
    op = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 32));
    // about a third of the instructions use register zero as source 1, so addresses follow imm
    rs1 = ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom_range(0, 31));
    return make_instr(op, 5'($urandom_range(0, 31)), rs1, 5'($urandom_range(0, 31)),
                      pick_imm(), $urandom());
  endfunction

  // Note the accepting edge for the driver
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
  end

  // Driver: present queued instructions with random gaps
  int unsigned send_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      send_gap <= 0;
    end else if (!(in_tvalid && !in_taken)) begin
      if (send_gap != 0 && !in_taken) begin
        send_gap <= send_gap - 1;
      end else if (instr_queue.size() != 0 && !hold_sender) begin
        if (in_taken && pick_gap() != 0) begin
          in_tvalid <= 1'b0;
          send_gap <= pick_gap();
        end else begin
          in_tdata <= {3'd0, instr_queue.pop_front()};
          in_tvalid <= 1'b1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  int unsigned stall_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Monitor: predict on each accepted word, compare each retired word
  always @(posedge clk) begin
    out_word_t got, exp_w;
    if (rst_n && in_tvalid && in_tready) retire_queue.push_back(execute_instr(in_tdata[84:0]));
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[65:0];
      if (retire_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        exp_w = retire_queue.pop_front();
        if (got.next_pc !== exp_w.next_pc || got.wrote_reg !== exp_w.wrote_reg ||
            got.write_value !== exp_w.write_value ||
            got.access_fault !== exp_w.access_fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pc=%h wr=%b val=%h flt=%b got pc=%h wr=%b val=%h flt=%b",
                     exp_w.next_pc, exp_w.wrote_reg, exp_w.write_value, exp_w.access_fault,
                     got.next_pc, got.wrote_reg, got.write_value, got.access_fault);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    for (int i = 0; i < 32; i++) shadow_regs[i] = '0;
    for (int i = 0; i < DataBytes; i++) shadow_mem[i] = '0;
    hold_sender = 1'b0;
    rst_n = 1'b0;
    // directed: seed registers, every operation, window edges, register zero
    instr_queue.push_back(make_instr(OP_LUI, 5'd1, 5'd0, 5'd0, 32'h8000_0000, 32'h0));
    instr_queue.push_back(make_instr(OP_ADDI, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF, 32'h4));
    instr_queue.push_back(make_instr(OP_ADDI, 5'd3, 5'd0, 5'd0, 32'd31, 32'h8));
    instr_queue.push_back(make_instr(OP_LUI, 5'd4, 5'd0, 5'd0, 32'h7FFF_FFFF, 32'hC));
    for (int op = 0; op <= 32; op += 2)
      instr_queue.push_back(make_instr(6'(op), 5'd5 + op[4:0] % 4, 5'd1, 5'd3,
                                       32'h0000_0400, 32'hFFFF_FFFC));
    instr_queue.push_back(make_instr(OP_SW, 5'd0, 5'd0, 5'd2, MemBase + DataBytes - 4, 32'h40));
    instr_queue.push_back(make_instr(OP_LW, 5'd9, 5'd0, 5'd0, MemBase + DataBytes - 3, 32'h44));
    instr_queue.push_back(make_instr(OP_LB, 5'd10, 5'd0, 5'd0, MemBase + DataBytes - 1, 32'h48));
    instr_queue.push_back(make_instr(OP_ADD, 5'd0, 5'd2, 5'd2, 32'h0, 32'h4C));
    instr_queue.push_back(make_instr(6'd63, 5'd7, 5'd1, 5'd2, 32'h0, 32'h50));
    for (int op = 1; op <= 31; op += 2)
      instr_queue.push_back(make_instr(6'(op), 5'd11, 5'd2, 5'd1, 32'h0000_03FF, 32'h100));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // random part, with one drain pause midway
    for (int n = 0; n < 950; n++) begin
      instr_queue.push_back(random_instr());
      if (n == 400) begin
        wait (instr_queue.size() == 0);
        @(negedge clk);
        hold_sender = 1'b1;
        wait (retire_queue.size() == 0 && !in_tvalid);
        hold_sender = 1'b0;
      end
    end
    wait (instr_queue.size() == 0);
    @(negedge clk);
    wait (!in_tvalid);
    wait (retire_queue.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && retire_queue.size() == 0)
      $display("rv32i_subset_execute_unit regression: pass");
    else
      $display("rv32i_subset_execute_unit regression: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rv32i_subset_execute_unit regression: fail");
    $finish;
  end
endmodule
